/* hdl/atps_pkg.sv */
// Package for the altitude triggered pump sequencer.
// Holds word layouts, phase codes, register indexes and reset values.
// No dependencies; every other file of the block imports it.
package atps_pkg;

  // Default width of the time base
  localparam int unsigned TIME_BITS_DEF = 32;

  // Field widths
  localparam int unsigned NOW_W  = 32;
  localparam int unsigned ALT_W  = 17;
  localparam int unsigned PRS_W  = 17;
  localparam int unsigned STEP_W = 16;
  localparam int unsigned TO_W   = 16;
  localparam int unsigned CODE_W = 3;

  // Stream word widths, padded to whole bytes
  localparam int unsigned IN_BITS    = NOW_W + 1 + ALT_W + 1 + PRS_W;
  localparam int unsigned IN_TDATA_W = ((IN_BITS + 7) / 8) * 8;
  localparam int unsigned OUT_BITS   = 1 + 1 + CODE_W + ALT_W;
  localparam int unsigned OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  // Configuration port
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 17;

  localparam logic [CFG_ADDR_W-1:0] CFG_START_ALT = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_ALT_STEP  = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_CUTOFF    = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_PUMP_TO   = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_MEAS_TO   = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] CFG_DRAIN_TO  = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] CFG_COOL_TO   = 3'd6;

  // Register reset values
  localparam logic signed [ALT_W-1:0] START_ALT_RST = 17'sd1000;
  localparam logic [STEP_W-1:0]       ALT_STEP_RST  = 16'd100;
  localparam logic [PRS_W-1:0]        CUTOFF_RST    = 17'd90000;
  localparam logic [TO_W-1:0]         PUMP_TO_RST   = 16'd4000;
  localparam logic [TO_W-1:0]         MEAS_TO_RST   = 16'd10000;
  localparam logic [TO_W-1:0]         DRAIN_TO_RST  = 16'd5000;
  localparam logic [TO_W-1:0]         COOL_TO_RST   = 16'd1000;

  // Largest altitude mark
  localparam logic signed [ALT_W-1:0] MARK_MAX = 17'sd65535;

  // Phase codes as seen on the result word
  localparam logic [CODE_W-1:0] PH_IDLE  = 3'd0;
  localparam logic [CODE_W-1:0] PH_PUMP  = 3'd1;
  localparam logic [CODE_W-1:0] PH_MEAS  = 3'd2;
  localparam logic [CODE_W-1:0] PH_DRAIN = 3'd3;
  localparam logic [CODE_W-1:0] PH_COOL  = 3'd4;

  // One-hot phase state
  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_PUMP  = 5'b00010,
    ST_MEAS  = 5'b00100,
    ST_DRAIN = 5'b01000,
    ST_COOL  = 5'b10000
  } phase_e;

  // Configuration registers
  typedef struct packed {
    logic signed [ALT_W-1:0] start_alt;
    logic [STEP_W-1:0]       alt_step;
    logic [PRS_W-1:0]        cutoff;
    logic [TO_W-1:0]         pump_to;
    logic [TO_W-1:0]         meas_to;
    logic [TO_W-1:0]         drain_to;
    logic [TO_W-1:0]         cool_to;
  } cfg_t;

  // One poll tick
  typedef struct packed {
    logic [PRS_W-1:0]        pressure_pa;
    logic                    pressure_valid;
    logic signed [ALT_W-1:0] altitude_m;
    logic                    altitude_valid;
    logic [NOW_W-1:0]        now_ms;
  } tick_t;

  // One result word
  typedef struct packed {
    logic signed [ALT_W-1:0] altitude_mark;
    logic [CODE_W-1:0]       phase;
    logic                    valve_open;
    logic                    pump_on;
  } res_t;

  // One-hot state to result code
  function automatic logic [CODE_W-1:0] phase_code(input phase_e st);
    logic [CODE_W-1:0] c;
    case (st)
      ST_IDLE:  c = PH_IDLE;
      ST_PUMP:  c = PH_PUMP;
      ST_MEAS:  c = PH_MEAS;
      ST_DRAIN: c = PH_DRAIN;
      ST_COOL:  c = PH_COOL;
      default:  c = PH_IDLE;
    endcase
    return c;
  endfunction

endpackage

/* hdl/atps_cfg.sv */
// Configuration register bank of the pump sequencer.
// Depends on atps_pkg for register indexes, widths and reset values.
module atps_cfg (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [atps_pkg::CFG_ADDR_W-1:0]    cfg_addr_i,
  input  logic [atps_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  output atps_pkg::cfg_t                     cfg_o,
  output logic                               mark_load_o
);
  import atps_pkg::*;

  cfg_t cfg_q, cfg_d;
  logic mark_load_q, mark_load_d;

  // Decode one write
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_addr_i)
        CFG_START_ALT: cfg_d.start_alt = cfg_wdata_i[ALT_W-1:0];
        CFG_ALT_STEP:  cfg_d.alt_step  = cfg_wdata_i[STEP_W-1:0];
        CFG_CUTOFF:    cfg_d.cutoff    = cfg_wdata_i[PRS_W-1:0];
        CFG_PUMP_TO:   cfg_d.pump_to   = cfg_wdata_i[TO_W-1:0];
        CFG_MEAS_TO:   cfg_d.meas_to   = cfg_wdata_i[TO_W-1:0];
        CFG_DRAIN_TO:  cfg_d.drain_to  = cfg_wdata_i[TO_W-1:0];
        CFG_COOL_TO:   cfg_d.cool_to   = cfg_wdata_i[TO_W-1:0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  // A new start altitude also reloads the mark; the load strobe is registered
  // so that the mark takes the value just written
  assign mark_load_d = cfg_we_i && (cfg_addr_i == CFG_START_ALT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_alt <= START_ALT_RST;
      cfg_q.alt_step  <= ALT_STEP_RST;
      cfg_q.cutoff    <= CUTOFF_RST;
      cfg_q.pump_to   <= PUMP_TO_RST;
      cfg_q.meas_to   <= MEAS_TO_RST;
      cfg_q.drain_to  <= DRAIN_TO_RST;
      cfg_q.cool_to   <= COOL_TO_RST;
      mark_load_q     <= 1'b0;
    end else begin
      cfg_q       <= cfg_d;
      mark_load_q <= mark_load_d;
    end
  end

  assign mark_load_o = mark_load_q;
  assign cfg_o       = cfg_q;

endmodule

/* hdl/atps_fsm.sv */
// Phase sequencer state and combinational tick update.
// Depends on atps_pkg for the tick, result and config types.
module atps_fsm #(
  parameter int unsigned TIME_BITS = atps_pkg::TIME_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 step_i,
  input  atps_pkg::tick_t                      tick_i,
  input  atps_pkg::cfg_t                       cfg_i,
  input  logic                                 mark_load_i,
  output atps_pkg::res_t                       res_o
);
  import atps_pkg::*;

  phase_e                  phase_q, phase_d, ph_mid;
  logic signed [ALT_W-1:0] mark_q, mark_d;
  logic [TIME_BITS-1:0]    start_q, start_d;
  logic [PRS_W-1:0]        held_q, held_d;
  logic                    pend_q, pend_d;
  logic                    pump_q, pump_d;
  logic                    valve_q, valve_d;

  logic [TIME_BITS-1:0]    now_t;
  logic [TIME_BITS-1:0]    diff;
  logic [TO_W-1:0]         limit;
  logic                    expired;
  logic                    crossed;
  logic signed [ALT_W:0]   mark_sum;

  // Elapsed time in the current phase, against that phase's timeout
  assign now_t = TIME_BITS'(tick_i.now_ms);
  assign diff  = now_t - start_q;

  always_comb begin
    case (phase_q)
      ST_PUMP:  limit = cfg_i.pump_to;
      ST_MEAS:  limit = cfg_i.meas_to;
      ST_DRAIN: limit = cfg_i.drain_to;
      ST_COOL:  limit = cfg_i.cool_to;
      default:  limit = '0;
    endcase
  end

  assign expired = diff > TIME_BITS'(limit);

  // Mark advance, saturating at the top
  assign mark_sum = {mark_q[ALT_W-1], mark_q} + $signed({2'b00, cfg_i.alt_step});
  assign crossed  = tick_i.altitude_valid && (tick_i.altitude_m > mark_q);

  // Tick update
  always_comb begin
    ph_mid  = phase_q;
    start_d = start_q;
    pump_d  = pump_q;
    valve_d = valve_q;
    mark_d  = mark_q;
    held_d  = held_q;
    pend_d  = pend_q;

    // Latch a fresh pressure sample first
    if (tick_i.pressure_valid) begin
      held_d = tick_i.pressure_pa;
      pend_d = 1'b1;
    end

    case (phase_q)
      ST_IDLE: begin
      end
      ST_PUMP: begin
        if ((pend_d && (held_d >= cfg_i.cutoff)) || expired) begin
          ph_mid  = ST_MEAS;
          pump_d  = 1'b0;
          start_d = now_t;
        end
        pend_d = 1'b0;
      end
      ST_MEAS: begin
        if (expired) begin
          ph_mid  = ST_DRAIN;
          pump_d  = 1'b1;
          valve_d = 1'b1;
          start_d = now_t;
        end
      end
      ST_DRAIN: begin
        if (expired) begin
          ph_mid  = ST_COOL;
          pump_d  = 1'b0;
          valve_d = 1'b1;
          start_d = now_t;
        end
      end
      ST_COOL: begin
        if (expired) begin
          ph_mid  = ST_IDLE;
          pump_d  = 1'b0;
          valve_d = 1'b1;
        end
      end
      default: begin
        ph_mid  = ST_IDLE;
        pump_d  = 1'b0;
        valve_d = 1'b1;
      end
    endcase

    // Altitude is checked last: may restart from a fresh idle
    phase_d = ph_mid;
    if (crossed) begin
      if (ph_mid == ST_IDLE) begin
        phase_d = ST_PUMP;
        pump_d  = 1'b1;
        valve_d = 1'b0;
        start_d = now_t;
      end
      if (!mark_sum[ALT_W] && mark_sum[ALT_W-1]) begin
        mark_d = MARK_MAX;
      end else begin
        mark_d = mark_sum[ALT_W-1:0];
      end
    end
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= ST_IDLE;
      mark_q  <= START_ALT_RST;
      start_q <= '0;
      held_q  <= '0;
      pend_q  <= 1'b0;
      pump_q  <= 1'b0;
      valve_q <= 1'b1;
    end else if (mark_load_i) begin
      mark_q  <= cfg_i.start_alt;
    end else if (step_i) begin
      phase_q <= phase_d;
      mark_q  <= mark_d;
      start_q <= start_d;
      held_q  <= held_d;
      pend_q  <= pend_d;
      pump_q  <= pump_d;
      valve_q <= valve_d;
    end
  end

  // Result after the update, for the output register
  assign res_o.pump_on       = pump_d;
  assign res_o.valve_open    = valve_d;
  assign res_o.phase         = phase_code(phase_d);
  assign res_o.altitude_mark = mark_d;

endmodule

/* hdl/altitude_triggered_pump_sequencer.sv */
// Altitude triggered pump sequencer, top level.
// Each input word is one poll tick (time, optional altitude, optional pressure).
// The block runs idle, pumping, measuring, draining and cooldown and returns
// one result word per tick: pump drive, valve drive, phase and altitude mark.
// Channels: s_axis input ticks, m_axis results, plus a write-only register
// port (cfg_we_i, cfg_addr_i, cfg_wdata_i) written while no tick is in flight.
// A tick taken waits in the input register; its result is registered in the
// result register. Throughput: one tick per cycle while results are taken;
// the phase update is combinational compare and add logic between the two.
// A tick waits in the input register while the result register is full and
// not taken, so a stalled receiver holds back at most two words before
// s_axis_tready drops. Data never drops or repeats.
// Reset (rst_ni, async, active low): registers return to their defaults,
// the phase to idle with pump off and valve open, and the mark to 1000 m.
// Depends on atps_pkg, atps_cfg and atps_fsm.
module altitude_triggered_pump_sequencer #(
  parameter int unsigned TIME_BITS = atps_pkg::TIME_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // now_ms[31:0], altitude_valid[32], altitude_m[49:33],
  // pressure_valid[50], pressure_pa[67:51], zero pad to 72
  input  logic [atps_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // pump_on[0], valve_open[1], phase[4:2], altitude_mark[21:5], zero pad to 24
  output logic [atps_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  input  logic                                cfg_we_i,
  input  logic [atps_pkg::CFG_ADDR_W-1:0]     cfg_addr_i,
  input  logic [atps_pkg::CFG_DATA_W-1:0]     cfg_wdata_i
);
  import atps_pkg::*;

  cfg_t  cfg;
  logic  mark_load;
  tick_t in_q;
  logic  in_valid_q;
  res_t  res;
  res_t  out_q;
  logic  out_valid_q;
  logic  adv;
  logic  step;

  // Pipeline advances when the result register is free or being taken
  assign adv           = !out_valid_q || m_axis_tready;
  assign step          = in_valid_q && adv;
  assign s_axis_tready = !in_valid_q || adv;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_q <= s_axis_tdata[IN_BITS-1:0];
    end
  end

  atps_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg),
    .mark_load_o (mark_load)
  );

  atps_fsm #(
    .TIME_BITS (TIME_BITS)
  ) u_fsm (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .tick_i      (in_q),
    .cfg_i       (cfg),
    .mark_load_i (mark_load),
    .res_o       (res)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_TDATA_W'(out_q);

endmodule

/* hdl/atps_chk.sv */
// Port-level checker for the pump sequencer, bound to the top level.
// Depends on atps_pkg for phase codes and word widths.
module atps_chk (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic [atps_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  input logic                               m_axis_tvalid,
  input logic                               m_axis_tready
);
  import atps_pkg::*;

  logic [CODE_W-1:0] ph;
  logic              pump;
  logic              valve;

  assign pump  = m_axis_tdata[0];
  assign valve = m_axis_tdata[1];
  assign ph    = m_axis_tdata[4:2];

  // A stalled word stays offered
  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result word withdrawn while stalled");

  // A stalled word keeps its data
  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result word changed while stalled");

  // Compressor runs only while pumping or draining
  a_pump_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (pump == ((ph == PH_PUMP) || (ph == PH_DRAIN))))
    else $error("pump drive does not match phase");

  // Valve is closed exactly while pumping or measuring
  a_valve_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (valve == !((ph == PH_PUMP) || (ph == PH_MEAS))))
    else $error("valve drive does not match phase");

endmodule

bind altitude_triggered_pump_sequencer atps_chk u_atps_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready)
);

/* test/tb.sv */
`timescale 1ns / 1ps
// Testbench for altitude_triggered_pump_sequencer: streams poll ticks in,
// predicts every status word and checks it against the output stream.
// Depends on atps_pkg and the block's top level; reads no files.
module tb;
  import atps_pkg::*;

  localparam int N_DIR       = 21;
  localparam int N_SETTINGS  = 7;
  localparam int HOLD_CYCLES = 80;
  localparam int ALT_LO      = -2048;
  localparam int ALT_HI      = 65535;
  localparam int PRS_HI      = 131071;

  // One row of the directed table; the status is typed in only where known is set
  typedef struct {
    logic [NOW_W-1:0]  now;
    bit                av;
    int                alt;
    bit                pv;
    int                prs;
    bit                known;
    bit                pump;
    bit                valve;
    logic [CODE_W-1:0] ph;
    int                mark;
  } dir_row_t;

  // One register setting and the number of random ticks run under it
  typedef struct {
    int start_alt;
    int step;
    int cutoff;
    int pump_to;
    int meas_to;
    int drain_to;
    int cool_to;
    int items;
  } setting_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic                   cfg_we_i = 1'b0;
  logic [CFG_ADDR_W-1:0]  cfg_addr_i = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata_i = '0;

  altitude_triggered_pump_sequencer u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  // 100 MHz clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Sequencer state as predicted
  logic [CODE_W-1:0] sq_phase;
  int                sq_mark;
  logic [NOW_W-1:0]  sq_start;
  int                sq_held;
  bit                sq_pending;
  bit                sq_pump;
  bit                sq_valve;

  // Register mirror
  int cf_start_alt, cf_step, cf_cutoff;
  int cf_pump_to, cf_meas_to, cf_drain_to, cf_cool_to;

  // Expected status words, oldest first
  res_t status_q[$];

  // Run control and bookkeeping
  logic [NOW_W-1:0] now_cur;
  int  tx_gap_pct = 0;
  int  rx_stall_pct = 0;
  bit  calm_run = 1'b0;
  bit  hold_rx_req = 1'b0;
  int  fail_cnt = 0;
  int  ticks_sent = 0;
  int  words_checked = 0;
  int  pump_starts = 0;
  int  mark_clamps = 0;

  dir_row_t dir_tab [N_DIR] = '{
    // out of reset, nothing fresh
    '{32'd0, 0, 0, 0, 0, 1, 0, 1, PH_IDLE, 1000},
    // top of time, lowest altitude, highest pressure latched while idle
    '{32'hFFFF_FFFF, 1, ALT_LO, 1, PRS_HI, 1, 0, 1, PH_IDLE, 1000},
    // altitude equal to the mark does not trigger
    '{32'd5, 1, 1000, 0, 0, 1, 0, 1, PH_IDLE, 1000},
    // one meter above starts pumping and advances the mark
    '{32'd20, 1, 1001, 0, 0, 1, 1, 0, PH_PUMP, 1100},
    // sample pending since idle is consumed now and is over cutoff
    '{32'd30, 0, 0, 0, 0, 1, 0, 0, PH_MEAS, 1100},
    // crossing outside idle moves the mark only; exactly at the timeout
    '{32'd10030, 1, ALT_HI, 0, 0, 1, 0, 0, PH_MEAS, 1200},
    // one past the timeout; a zero sample is left pending
    '{32'd10031, 0, 0, 1, 0, 1, 1, 1, PH_DRAIN, 1200},
    '{32'd15031, 0, 0, 0, 0, 0, 0, 0, PH_IDLE, 0},
    '{32'd15032, 0, 0, 0, 0, 1, 0, 1, PH_COOL, 1200},
    // cooldown ends and the same tick starts the next cycle
    '{32'd16033, 1, 1201, 0, 0, 1, 1, 0, PH_PUMP, 1300},
    // stale zero sample consumed, below cutoff
    '{32'd16040, 0, 0, 0, 0, 0, 0, 0, PH_IDLE, 0},
    '{32'd16050, 0, 0, 1, 89999, 0, 0, 0, PH_IDLE, 0},
    // pump timeout boundary
    '{32'd20033, 0, 0, 0, 0, 0, 0, 0, PH_IDLE, 0},
    '{32'd20034, 0, 0, 0, 0, 0, 0, 0, PH_IDLE, 0},
    // far jump ends measuring, then the difference wraps through zero
    '{32'hFFFF_FF00, 0, 0, 0, 0, 0, 0, 0, PH_IDLE, 0},
    '{32'h0000_1288, 0, 0, 0, 0, 0, 0, 0, PH_IDLE, 0},
    '{32'h0000_1289, 0, 0, 0, 0, 0, 0, 0, PH_IDLE, 0},
    '{32'h0000_1671, 0, 0, 0, 0, 0, 0, 0, PH_IDLE, 0},
    '{32'h0000_1672, 1, 0, 0, 0, 0, 0, 0, PH_IDLE, 0},
    // pressure at cutoff arrives on the starting tick, ends pumping next tick
    '{32'h0000_1673, 1, 1301, 1, 90000, 0, 0, 0, PH_IDLE, 0},
    '{32'h0000_1674, 0, 0, 0, 0, 0, 0, 0, PH_IDLE, 0}
  };

  setting_t settings_tab [N_SETTINGS] = '{
    '{1000, 100, 90000, 4000, 10000, 5000, 1000, 200},
    '{ALT_LO, 0, 0, 0, 0, 0, 0, 200},
    '{65000, 65535, PRS_HI, 65535, 65535, 65535, 65535, 180},
    '{ALT_HI, 50, 100, 100, 100, 100, 100, 100},
    '{0, 1, 50000, 10, 20, 5, 3, 220},
    '{60000, 700, 65536, 300, 200, 100, 50, 200},
    '{-100, 37, 1000, 1, 2, 1, 0, 230}
  };

  function automatic void reset_sequencer_model();
    cf_start_alt = 1000;
    cf_step      = 100;
    cf_cutoff    = 90000;
    cf_pump_to   = 4000;
    cf_meas_to   = 10000;
    cf_drain_to  = 5000;
    cf_cool_to   = 1000;
    sq_phase     = PH_IDLE;
    sq_mark      = cf_start_alt;
    sq_start     = '0;
    sq_held      = 0;
    sq_pending   = 1'b0;
    sq_pump      = 1'b0;
    sq_valve     = 1'b1;
  endfunction

  // Wrapping time since the phase began, strictly over the limit
  function automatic bit past_limit(input logic [NOW_W-1:0] now, input int lim);
    logic [NOW_W-1:0] since;
    since = now - sq_start;
    return since > lim[NOW_W-1:0];
  endfunction

  // One poll tick through the predicted sequencer
  task automatic advance_sequencer(input tick_t t, output res_t r);
    int alt;
    bit leave;
    alt = {{(32-ALT_W){t.altitude_m[ALT_W-1]}}, t.altitude_m};
    leave = 1'b0;
    // the sample of this tick is latched before the phase logic
    if (t.pressure_valid) begin
      sq_held = int'(t.pressure_pa);
      sq_pending = 1'b1;
    end
    case (sq_phase)
      PH_IDLE: begin
      end
      PH_PUMP: begin
        if (sq_pending) begin
          sq_pending = 1'b0;
          leave = (sq_held >= cf_cutoff);
        end
        if (leave || past_limit(t.now_ms, cf_pump_to)) begin
          sq_phase = PH_MEAS;
          sq_pump  = 1'b0;
          sq_start = t.now_ms;
        end
      end
      PH_MEAS: begin
        if (past_limit(t.now_ms, cf_meas_to)) begin
          sq_phase = PH_DRAIN;
          sq_pump  = 1'b1;
          sq_valve = 1'b1;
          sq_start = t.now_ms;
        end
      end
      PH_DRAIN: begin
        if (past_limit(t.now_ms, cf_drain_to)) begin
          sq_phase = PH_COOL;
          sq_pump  = 1'b0;
          sq_valve = 1'b1;
          sq_start = t.now_ms;
        end
      end
      PH_COOL: begin
        // back to idle keeps the old phase start
        if (past_limit(t.now_ms, cf_cool_to)) begin
          sq_phase = PH_IDLE;
          sq_pump  = 1'b0;
          sq_valve = 1'b1;
        end
      end
      default: begin
        sq_phase = PH_IDLE;
        sq_pump  = 1'b0;
        sq_valve = 1'b1;
      end
    endcase
    // altitude is looked at last, so a cycle can start on the idle tick
    if (t.altitude_valid && alt > sq_mark) begin
      if (sq_phase == PH_IDLE) begin
        sq_phase = PH_PUMP;
        sq_pump  = 1'b1;
        sq_valve = 1'b0;
        sq_start = t.now_ms;
        pump_starts++;
      end
      if (sq_mark + cf_step > int'(MARK_MAX)) begin
        sq_mark = int'(MARK_MAX);
        mark_clamps++;
      end else begin
        sq_mark = sq_mark + cf_step;
      end
    end
    r.pump_on       = sq_pump;
    r.valve_open    = sq_valve;
    r.phase         = sq_phase;
    r.altitude_mark = sq_mark[ALT_W-1:0];
  endtask

  // Register write, one per cycle; the caller lowers the enable
  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input int val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= val[CFG_DATA_W-1:0];
    @(posedge clk_i);
    case (idx)
      CFG_START_ALT: begin
        cf_start_alt = val;
        sq_mark = val;
      end
      CFG_ALT_STEP: cf_step     = val;
      CFG_CUTOFF:   cf_cutoff   = val;
      CFG_PUMP_TO:  cf_pump_to  = val;
      CFG_MEAS_TO:  cf_meas_to  = val;
      CFG_DRAIN_TO: cf_drain_to = val;
      CFG_COOL_TO:  cf_cool_to  = val;
      default: begin
      end
    endcase
  endtask

  task automatic load_settings(input setting_t st);
    write_reg(CFG_START_ALT, st.start_alt);
    write_reg(CFG_ALT_STEP, st.step);
    write_reg(CFG_CUTOFF, st.cutoff);
    write_reg(CFG_PUMP_TO, st.pump_to);
    write_reg(CFG_MEAS_TO, st.meas_to);
    write_reg(CFG_DRAIN_TO, st.drain_to);
    write_reg(CFG_COOL_TO, st.cool_to);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Offer one tick, wait for the handshake, then record its status word
  task automatic offer_tick(input tick_t t, input bit typed, input res_t typed_res);
    res_t r;
    int gap;
    if (!calm_run && $urandom_range(0, 99) < tx_gap_pct) begin
      gap = $urandom_range(1, 18);
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(IN_TDATA_W-IN_BITS){1'b0}}, t};
    do @(posedge clk_i); while (!s_axis_tready);
    advance_sequencer(t, r);
    status_q.push_back(typed ? typed_res : r);
    ticks_sent++;
  endtask

  // Stop sending and let every expected word come back
  task automatic drain_results();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (status_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Random tick, mostly aimed at the current mark, cutoff and phase limit
  task automatic compose_tick(output tick_t t);
    int sel, lim, alt, prs;
    logic [NOW_W-1:0] since;
    case (sq_phase)
      PH_PUMP:  lim = cf_pump_to;
      PH_MEAS:  lim = cf_meas_to;
      PH_DRAIN: lim = cf_drain_to;
      PH_COOL:  lim = cf_cool_to;
      default:  lim = cf_meas_to;
    endcase
    since = now_cur - sq_start;
    sel = $urandom_range(0, 99);
    if (sel < 35) begin
      now_cur = now_cur + $urandom_range(0, 3);
    end else if (sel < 75) begin
      now_cur = now_cur + $urandom_range(0, lim / 3 + 2);
    end else if (sel < 95 && since <= lim[NOW_W-1:0]) begin
      // land on the limit or one past it
      now_cur = sq_start + lim + $urandom_range(0, 1);
    end else if (sel < 95) begin
      now_cur = now_cur + 1;
    end else begin
      now_cur = $urandom();
    end
    t.now_ms = now_cur;

    t.altitude_valid = $urandom_range(0, 99) < ((sq_phase == PH_IDLE) ? 60 : 25);
    if ($urandom_range(0, 3) != 0)
      alt = sq_mark - 8 + int'($urandom_range(0, 160));
    else
      alt = int'($urandom_range(0, ALT_HI - ALT_LO)) + ALT_LO;
    if (alt < ALT_LO) alt = ALT_LO;
    if (alt > ALT_HI) alt = ALT_HI;
    t.altitude_m = alt[ALT_W-1:0];

    t.pressure_valid = $urandom_range(0, 99) < ((sq_phase == PH_PUMP) ? 45 : 25);
    if ($urandom_range(0, 1) != 0)
      prs = cf_cutoff - 2 + int'($urandom_range(0, 4));
    else
      prs = int'($urandom_range(0, PRS_HI));
    if (prs < 0) prs = 0;
    if (prs > PRS_HI) prs = PRS_HI;
    t.pressure_pa = prs[PRS_W-1:0];
  endtask

  // Receiver: random stalls plus one long hold-off on request
  initial begin : rx_ready
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        m_axis_tready <= 1'b0;
        hold_left--;
      end else if (hold_rx_req) begin
        hold_rx_req = 1'b0;
        hold_left = HOLD_CYCLES;
        m_axis_tready <= 1'b0;
      end else if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= 1'b1;
        if (!calm_run && $urandom_range(0, 99) < rx_stall_pct)
          stall_left = $urandom_range(1, 18);
      end
    end
  end

  // Output check against the oldest expected word
  always @(posedge clk_i) begin : status_check
    res_t got;
    res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[OUT_BITS-1:0];
      if (status_q.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= 10)
          $display("%0t: status word %h with nothing expected", $realtime, got);
      end else begin
        want = status_q.pop_front();
        words_checked++;
        if (got.pump_on !== want.pump_on || got.valve_open !== want.valve_open ||
            got.phase !== want.phase || got.altitude_mark !== want.altitude_mark) begin
          fail_cnt++;
          if (fail_cnt <= 10)
            $display("%0t: word %0d exp pump %b valve %b phase %0d mark %0d, got %b %b %0d %0d",
                     $realtime, words_checked, want.pump_on, want.valve_open, want.phase,
                     want.altitude_mark, got.pump_on, got.valve_open, got.phase,
                     got.altitude_mark);
        end
      end
    end
  end

  // Main sequence: reset, directed table, then random ticks per setting
  initial begin : stimulus
    tick_t t;
    res_t  typed;
    int    i;
    int    s;
    int    k;
    reset_sequencer_model();
    now_cur = '0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed table with light idling on both sides
    tx_gap_pct   = 20;
    rx_stall_pct = 20;
    for (i = 0; i < N_DIR; i++) begin
      t.now_ms         = dir_tab[i].now;
      t.altitude_valid = dir_tab[i].av;
      t.altitude_m     = dir_tab[i].alt[ALT_W-1:0];
      t.pressure_valid = dir_tab[i].pv;
      t.pressure_pa    = dir_tab[i].prs[PRS_W-1:0];
      typed.pump_on       = dir_tab[i].pump;
      typed.valve_open    = dir_tab[i].valve;
      typed.phase         = dir_tab[i].ph;
      typed.altitude_mark = dir_tab[i].mark[ALT_W-1:0];
      offer_tick(t, dir_tab[i].known, typed);
    end
    now_cur = dir_tab[N_DIR-1].now;
    drain_results();

    // random ticks under each register setting
    for (s = 0; s < N_SETTINGS; s++) begin
      calm_run = (s == N_SETTINGS - 1);
      load_settings(settings_tab[s]);
      for (k = 0; k < settings_tab[s].items; k++) begin
        if (k % 50 == 0) begin
          case ($urandom_range(0, 2))
            0: tx_gap_pct = 0;
            1: tx_gap_pct = 10;
            default: tx_gap_pct = 35;
          endcase
          case ($urandom_range(0, 2))
            0: rx_stall_pct = 0;
            1: rx_stall_pct = 10;
            default: rx_stall_pct = 35;
          endcase
        end
        // long receiver hold-off while ticks keep coming
        if ((s == 1 && k == 50) || (s == 4 && k == 100))
          hold_rx_req = 1'b1;
        // sender pause until the pipeline is empty
        if (s == 2 && k == 90)
          drain_results();
        compose_tick(t);
        offer_tick(t, 1'b0, '0);
      end
      drain_results();
    end

    repeat (10) @(posedge clk_i);
    $display("Sent %0d poll ticks, checked %0d status words over %0d register settings",
             ticks_sent, words_checked, N_SETTINGS);
    $display("Pump cycles started: %0d, mark saturations: %0d", pump_starts, mark_clamps);
    if (fail_cnt == 0 && status_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Hang guard, far above the slowest legal run
  initial begin : watchdog
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

/* files.f */
hdl/atps_pkg.sv
hdl/atps_cfg.sv
hdl/atps_fsm.sv
hdl/altitude_triggered_pump_sequencer.sv
hdl/atps_chk.sv
test/tb.sv
